@@ design/kli_pkg.sv @@
// Shared types and constants for the keyframe linear interpolator.
`default_nettype none

package kli_pkg;

  localparam int VAL_W     = 32;  // Q16.16 times and values
  localparam int IDX_W     = 8;   // key_index field
  localparam int CNT_W     = 9;   // keys_in_use register
  localparam int FRAC_W    = 16;  // interpolation fraction, Q0.16
  localparam int DIV_STEPS = VAL_W + FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    STAT_SAMPLE = 2'd0,
    STAT_WRITE  = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_DIV,
    S_SUB,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  // One table entry: time and xyz value.
  typedef struct packed {
    logic        [VAL_W-1:0] kt;
    logic signed [VAL_W-1:0] kx;
    logic signed [VAL_W-1:0] ky;
    logic signed [VAL_W-1:0] kz;
  } key_t;

endpackage

`default_nettype wire

@@ design/kli_ifs.sv @@
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface kli_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic        [kli_pkg::IDX_W-1:0] key_index;
  logic        [kli_pkg::VAL_W-1:0] key_time;
  logic signed [kli_pkg::VAL_W-1:0] key_x;
  logic signed [kli_pkg::VAL_W-1:0] key_y;
  logic signed [kli_pkg::VAL_W-1:0] key_z;
  logic        [kli_pkg::VAL_W-1:0] query_time;

  modport source (output valid, req_type, key_index, key_time, key_x, key_y, key_z,
                  query_time, input ready);
  modport sink   (input valid, req_type, key_index, key_time, key_x, key_y, key_z,
                  query_time, output ready);
  modport mon    (input valid, ready, req_type, key_index, key_time, key_x, key_y, key_z,
                  query_time);
endinterface

interface kli_rsp_if;
  logic                             valid;
  logic                             ready;
  kli_pkg::status_t                 status;
  logic signed [kli_pkg::VAL_W-1:0] out_x;
  logic signed [kli_pkg::VAL_W-1:0] out_y;
  logic signed [kli_pkg::VAL_W-1:0] out_z;

  modport source (output valid, status, out_x, out_y, out_z, input ready);
  modport sink   (input valid, status, out_x, out_y, out_z, output ready);
  modport mon    (input valid, ready, status, out_x, out_y, out_z);
endinterface

interface kli_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [kli_pkg::CNT_W-1:0] keys_in_use;

  modport source (output valid, keys_in_use, input ready);
  modport sink   (input valid, keys_in_use, output ready);
endinterface

`default_nettype wire

@@ design/kli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/keyframe_linear_interpolator.sv @@
// Top level: keyframe table, linear scan, serial fraction divider and shared lerp multiplier.
//
//   channel | dir | payload                                               | transfer when
//   --------+-----+-------------------------------------------------------+------------------
//   req     | in  | req_type key_index key_time key_x key_y key_z query_time | valid && ready
//   rsp     | out | status out_x out_y out_z                              | valid && ready
//   cfg     | in  | keys_in_use                                           | valid && ready
//
// A write goes from the request transfer to S_DONE, then to the response register.
// A sample checks the first and last entries, scans for the bracketing entry (one table
// read per cycle), runs the one-bit-a-cycle fraction divider, then the lerp for x, y and z.
// Edge cases (empty table, query outside the keys) end from S_IDLE, S_FIRST or S_LAST.
// req.ready is high only when the sequencer is idle; rsp is a register, so a stalled
// response does not stop the next request. cfg.ready is always high. Reset clears the
// sequencer, the response valid and keys_in_use; the table is not cleared.
`default_nettype none

module keyframe_linear_interpolator #(
  parameter int MAX_KEYS = 256
) (
  input  logic      clk,
  input  logic      rst,
  kli_req_if.sink   req,
  kli_rsp_if.source rsp,
  kli_cfg_if.sink   cfg
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int KW = $bits(kli_pkg::key_t);
  localparam int PW = kli_pkg::VAL_W + kli_pkg::FRAC_W + 2;

  kli_pkg::state_t state, state_next;

  logic [kli_pkg::CNT_W-1:0] keys_in_use;
  logic [kli_pkg::CNT_W-1:0] n_keys;
  logic [kli_pkg::CNT_W-1:0] last;
  logic [kli_pkg::CNT_W-1:0] scan_idx;

  logic                      req_fire;
  logic                      ram_we;
  kli_pkg::key_t             wdata;
  kli_pkg::key_t             rd;
  logic [AW-1:0]             rd_addr;

  logic [kli_pkg::VAL_W-1:0] q;
  kli_pkg::key_t             prev;
  kli_pkg::key_t             nxt;

  // fraction divider
  logic [kli_pkg::DIV_STEPS-1:0] dvd;
  logic [kli_pkg::VAL_W-1:0]     rem, rem_next, den;
  logic [kli_pkg::VAL_W:0]       trial, trial_sub;
  logic                          take;
  logic [kli_pkg::FRAC_W-1:0]    quo;
  logic [kli_pkg::STEP_W-1:0]    cnt;

  // shared lerp unit
  logic [1:0]                        k;
  logic signed [kli_pkg::VAL_W-1:0]  a_sel, b_sel, sum;
  logic signed [kli_pkg::VAL_W:0]    diff;
  logic signed [PW-1:0]              prod;

  kli_pkg::status_t                 res_status;
  logic signed [kli_pkg::VAL_W-1:0] res_x, res_y, res_z;

  logic first_hit, last_hit, scan_hit, out_free;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use <= '0;
    end else if (cfg.valid && cfg.ready) begin
      keys_in_use <= cfg.keys_in_use;
    end
  end

  always_comb begin
    n_keys = (32'(keys_in_use) > 32'(MAX_KEYS)) ? kli_pkg::CNT_W'(MAX_KEYS) : keys_in_use;
    last   = n_keys - kli_pkg::CNT_W'(1);
  end

  // table
  assign req_fire = req.valid && req.ready;
  assign ram_we   = req_fire && (req.req_type == kli_pkg::REQ_WRITE) &&
                    (32'(req.key_index) < 32'(MAX_KEYS));
  assign wdata    = {req.key_time, req.key_x, req.key_y, req.key_z};

  kli_ram #(
    .WIDTH(KW),
    .DEPTH(MAX_KEYS)
  ) u_kli_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(req.key_index)),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rd)
  );

  // compares on the entry just read
  assign first_hit = (n_keys == kli_pkg::CNT_W'(1)) || (q <= rd.kt);
  assign last_hit  = (q >= rd.kt);
  assign scan_hit  = (q < rd.kt);
  assign out_free  = !rsp.valid || rsp.ready;

  // divider step: restoring, one quotient bit a cycle
  always_comb begin
    trial     = {rem, dvd[kli_pkg::DIV_STEPS-1]};
    trial_sub = trial - {1'b0, den};
    take      = (trial >= {1'b0, den});
    rem_next  = take ? trial_sub[kli_pkg::VAL_W-1:0] : trial[kli_pkg::VAL_W-1:0];
  end

  always_comb begin
    case (k)
      2'd0:    begin a_sel = prev.kx; b_sel = nxt.kx; end
      2'd1:    begin a_sel = prev.ky; b_sel = nxt.ky; end
      default: begin a_sel = prev.kz; b_sel = nxt.kz; end
    endcase
    sum = a_sel + prod[kli_pkg::VAL_W+kli_pkg::FRAC_W-1:kli_pkg::FRAC_W];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kli_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    req.ready  = 1'b0;
    case (state)
      kli_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req_fire) begin
          if (req.req_type == kli_pkg::REQ_WRITE || n_keys == '0) begin
            state_next = kli_pkg::S_DONE;
          end else begin
            state_next = kli_pkg::S_FIRST;
          end
        end
      end
      kli_pkg::S_FIRST: begin
        rd_addr    = AW'(last);
        state_next = first_hit ? kli_pkg::S_DONE : kli_pkg::S_LAST;
      end
      kli_pkg::S_LAST: begin
        rd_addr    = AW'(1);
        state_next = last_hit ? kli_pkg::S_DONE : kli_pkg::S_SCAN;
      end
      kli_pkg::S_SCAN: begin
        rd_addr    = AW'(scan_idx + kli_pkg::CNT_W'(1));
        state_next = scan_hit ? kli_pkg::S_DIV : kli_pkg::S_SCAN;
      end
      kli_pkg::S_DIV: begin
        if (cnt == '0) begin
          state_next = kli_pkg::S_SUB;
        end
      end
      kli_pkg::S_SUB: state_next = kli_pkg::S_MUL;
      kli_pkg::S_MUL: state_next = kli_pkg::S_ADD;
      kli_pkg::S_ADD: state_next = (k == 2'd2) ? kli_pkg::S_DONE : kli_pkg::S_SUB;
      kli_pkg::S_DONE: begin
        if (out_free) begin
          state_next = kli_pkg::S_IDLE;
        end
      end
      default: state_next = kli_pkg::S_IDLE;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cnt      <= '0;
      k        <= '0;
    end else begin
      case (state)
        kli_pkg::S_LAST: scan_idx <= kli_pkg::CNT_W'(1);
        kli_pkg::S_SCAN: begin
          if (scan_hit) begin
            cnt <= kli_pkg::STEP_W'(kli_pkg::DIV_STEPS - 1);
          end else begin
            scan_idx <= scan_idx + kli_pkg::CNT_W'(1);
          end
        end
        kli_pkg::S_DIV: begin
          cnt <= cnt - kli_pkg::STEP_W'(1);
          k   <= '0;
        end
        kli_pkg::S_ADD: k <= k + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      kli_pkg::S_IDLE: begin
        q          <= req.query_time;
        res_status <= (req.req_type == kli_pkg::REQ_WRITE) ? kli_pkg::STAT_WRITE
                                                           : kli_pkg::STAT_EMPTY;
        res_x      <= '0;
        res_y      <= '0;
        res_z      <= '0;
      end
      kli_pkg::S_FIRST: begin
        prev       <= rd;
        res_status <= kli_pkg::STAT_SAMPLE;
        res_x      <= rd.kx;
        res_y      <= rd.ky;
        res_z      <= rd.kz;
      end
      kli_pkg::S_LAST: begin
        res_x <= rd.kx;
        res_y <= rd.ky;
        res_z <= rd.kz;
      end
      kli_pkg::S_SCAN: begin
        if (scan_hit) begin
          nxt <= rd;
          dvd <= {q - prev.kt, kli_pkg::FRAC_W'(0)};
          den <= rd.kt - prev.kt;
          rem <= '0;
        end else begin
          prev <= rd;
        end
      end
      kli_pkg::S_DIV: begin
        dvd <= dvd << 1;
        rem <= rem_next;
        quo <= {quo[kli_pkg::FRAC_W-2:0], take};
      end
      kli_pkg::S_SUB: begin
        diff <= {b_sel[kli_pkg::VAL_W-1], b_sel} - {a_sel[kli_pkg::VAL_W-1], a_sel};
      end
      kli_pkg::S_MUL: begin
        prod <= PW'(diff) * PW'($signed({1'b0, quo}));
      end
      kli_pkg::S_ADD: begin
        case (k)
          2'd0:    res_x <= sum;
          2'd1:    res_y <= sum;
          default: res_z <= sum;
        endcase
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == kli_pkg::S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kli_pkg::S_DONE && out_free) begin
      rsp.status <= res_status;
      rsp.out_x  <= res_x;
      rsp.out_y  <= res_y;
      rsp.out_z  <= res_z;
    end
  end

endmodule

`default_nettype wire

@@ design/kli_checker.sv @@
// Port checker for the keyframe linear interpolator, bound to the top level.
`default_nettype none

module kli_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input kli_pkg::status_t          rsp_status,
  input logic [kli_pkg::VAL_W-1:0] rsp_out_x,
  input logic [kli_pkg::VAL_W-1:0] rsp_out_y,
  input logic [kli_pkg::VAL_W-1:0] rsp_out_z
);

  // the sequencer is busy in the cycle after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still in hand");

  // values are zero on write and empty-table responses
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != kli_pkg::STAT_SAMPLE |->
      rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)
    else $error("non-sample response carries a value");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z))
    else $error("stalled response changed");

  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> $past(rsp_ready))
    else $error("response withdrawn without a transfer");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_status(rsp.status),
  .rsp_out_x (rsp.out_x),
  .rsp_out_y (rsp.out_y),
  .rsp_out_z (rsp.out_z)
);

`default_nettype wire
